/* rtl/srms_pkg.sv */
// Package for the stable run merge sorter: word types and fixed field widths.
// Depends on nothing; the top level and the checker import it.
`timescale 1ns / 1ps
`default_nettype none
package srms_pkg;
    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int ELEM_W = KEY_W + TAG_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             is_last;
    } t_in;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             end_of_list;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_elem;
endpackage
`default_nettype wire

/* rtl/srms_mem.sv */
// Element memory: one write port, two registered read ports.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none
module srms_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule
`default_nettype wire

/* rtl/stable_run_merge_sorter.sv */
// Top level of the stable run merge sorter: load, merge passes and emission.
// Depends on srms_pkg and srms_mem.
`timescale 1ns / 1ps
`default_nettype none
// Words are loaded one per cycle into memory A until a word with is_last set
// arrives or MAX_ELEMENTS words are held. The list is then sorted stably in
// ascending unsigned key order by bottom-up merge passes that ping-pong
// between two memories; equal keys keep their arrival order. For each merged
// element both heads are read, then compared and the smaller one written.
// Each pair of runs has a set-up step first, each of the ceil(log2(n))
// passes has a start step, and a final check ends the sort. Emission then
// reads, loads and offers each word in turn, holding a word while the output
// is stalled. No input is taken while a list is being sorted or emitted;
// the memories need no clearing after reset.
module stable_run_merge_sorter #(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire srms_pkg::t_in   i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output srms_pkg::t_out       o_data
);
    import srms_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int XW = CW + 2;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_PAIR  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_ERD   = 3'd5;
    localparam logic [2:0] S_ELD   = 3'd6;
    localparam logic [2:0] S_EWAIT = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [XW-1:0] r_w, n_w;
    logic [CW-1:0] r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_src, n_src;
    t_out          r_out, n_out;

    logic [ELEM_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    t_elem             head_l, head_r, wr_elem;
    logic              a_we, b_we, take_left, merge_we;
    logic [AW-1:0]     waddr, raddr0, raddr1;
    logic [XW-1:0]     sum_mid, sum_hi, w_dbl;

    assign head_l = r_src ? t_elem'(b_rd0) : t_elem'(a_rd0);
    assign head_r = r_src ? t_elem'(b_rd1) : t_elem'(a_rd1);

    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || (head_l.key <= head_r.key));
    assign merge_we  = (r_state == S_WR);

    always_comb begin
        wr_elem = take_left ? head_l : head_r;
        waddr   = r_k[AW-1:0];
        if (r_state == S_LOAD) begin
            wr_elem.key = i_data.key;
            wr_elem.tag = i_data.tag;
        end
    end

    // Loading always fills A; a merge writes the memory that is not the source.
    assign a_we = (r_state == S_LOAD && i_valid) || (merge_we && r_src);
    assign b_we = merge_we && !r_src;

    assign raddr0 = (r_state == S_ERD) ? r_k[AW-1:0] : r_i[AW-1:0];
    assign raddr1 = r_j[AW-1:0];

    assign sum_mid = XW'(r_lo) + r_w;
    assign sum_hi  = XW'(r_lo) + (r_w << 1);
    assign w_dbl   = r_w << 1;

    srms_mem #(.DEPTH(MAX_ELEMENTS), .WIDTH(ELEM_W)) u_mem_a (
        .i_clk    (i_clk),
        .i_we     (a_we),
        .i_waddr  (waddr),
        .i_wdata  (wr_elem),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    srms_mem #(.DEPTH(MAX_ELEMENTS), .WIDTH(ELEM_W)) u_mem_b (
        .i_clk    (i_clk),
        .i_we     (b_we),
        .i_waddr  (waddr),
        .i_wdata  (wr_elem),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    assign o_ready = (r_state == S_LOAD);
    assign o_valid = (r_state == S_EWAIT);
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_src   = r_src;
        n_out   = r_out;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    n_k = r_k + 1'b1;
                    if (i_data.is_last || (r_k + 1'b1 == CW'(MAX_ELEMENTS))) begin
                        n_n     = r_k + 1'b1;
                        n_w     = XW'(1);
                        n_src   = 1'b0;
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                n_lo = '0;
                if (r_w >= XW'(r_n)) begin
                    n_k     = '0;
                    n_state = S_ERD;
                end else begin
                    n_state = S_PAIR;
                end
            end
            S_PAIR: begin
                // Clip both run ends to the list length.
                n_mid   = (sum_mid < XW'(r_n)) ? sum_mid[CW-1:0] : r_n;
                n_hi    = (sum_hi < XW'(r_n)) ? sum_hi[CW-1:0] : r_n;
                n_i     = r_lo;
                n_j     = n_mid;
                n_k     = r_lo;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (take_left) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = S_RD;
                if (r_k + 1'b1 == r_hi) begin
                    if (r_hi == r_n) begin
                        n_w     = w_dbl;
                        n_src   = !r_src;
                        n_state = S_PASS;
                    end else begin
                        n_lo    = r_hi;
                        n_state = S_PAIR;
                    end
                end
            end
            S_ERD: begin
                n_state = S_ELD;
            end
            S_ELD: begin
                n_out.sorted_key  = head_l.key;
                n_out.sorted_tag  = head_l.tag;
                n_out.end_of_list = (r_k + 1'b1 == r_n);
                n_state           = S_EWAIT;
            end
            S_EWAIT: begin
                if (i_ready) begin
                    if (r_out.end_of_list) begin
                        n_k     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
        r_n   <= n_n;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_i   <= n_i;
        r_j   <= n_j;
        r_src <= n_src;
        r_out <= n_out;
    end
endmodule
`default_nettype wire

/* rtl/srms_checker.sv */
// Port-level checks for the stable run merge sorter, bound to the top level.
// Depends on srms_pkg and stable_run_merge_sorter.
`timescale 1ns / 1ps
`default_nettype none
module srms_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_ready,
    input wire srms_pkg::t_in  i_data,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire srms_pkg::t_out o_data
);
    import srms_pkg::*;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output word changed while stalled");

    // Loading and emission never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while a word is offered");

    // The last word of a list closes the input side.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.is_last) |=> !o_ready)
        else $error("input still open after last word");

    // After the final output word the block returns to loading.
    a_end_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.end_of_list) |=> (!o_valid && o_ready))
        else $error("block did not return to loading after end of list");
endmodule

bind stable_run_merge_sorter srms_checker u_srms_checker (.*);
`default_nettype wire
